FILE: hw/rtl/rmcb_pkg.sv
package rmcb_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int LOG_W      = 4;
    localparam int LEVEL_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE   = 1'd1;

    localparam logic [LOG_W-1:0] RST_IMAGE_SIZE = 4'd10;
    localparam logic [LOG_W-1:0] RST_MIN_SIZE   = 4'd7;

    localparam logic [9:0] ROUND_HALF = 10'd2;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

    typedef struct packed {
        logic [8:0] blue;
        logic [8:0] green;
        logic [8:0] red;
    } t_sum;

    typedef struct packed {
        t_pix pix;
        logic level_end;
    } t_res;

    typedef struct packed {
        logic             en;
        logic             clear;
        logic [LOG_W-1:0] size_log2;
        logic [LOG_W-1:0] levels;
    } t_ctl;

endpackage

FILE: hw/rtl/rgb_mip_chain_box_downsample.sv
// Channel   Direction  Handshake           Payload
// pixel     in         i_valid / o_stall   i_red_in, i_green_in, i_blue_in
// result    out        o_valid / i_stall   o_level, o_*_out, o_level_end, o_run_last
// config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// One source pixel is taken per cycle while o_stall is low; each mip level is one cell of the
// chain, and the results of a pixel pass through each cell's register to the output register.
// A pixel that completes k levels holds the output register for k transfers; the chain stalls
// while the last cell holds results and the run in the output register does not end this cycle.
// Reset clears the positions, held pixels and pipeline and sets the log2 sizes to 10 and 7;
// the line stores are not cleared, as each entry is written on an even row before it is read.
module rgb_mip_chain_box_downsample
    import rmcb_pkg::*;
#(
    parameter int MAX_SIZE   = 4096,
    parameter int MAX_LEVELS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_red_in,
    input  logic [7:0]            i_green_in,
    input  logic [7:0]            i_blue_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [LEVEL_W-1:0]    o_level,
    output logic [7:0]            o_red_out,
    output logic [7:0]            o_green_out,
    output logic [7:0]            o_blue_out,
    output logic                  o_level_end,
    output logic                  o_run_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TOP   = $clog2(MAX_SIZE + 1) - 1;
    localparam int NCELL = (MAX_LEVELS < TOP) ? MAX_LEVELS : TOP;
    localparam int CNT_W = $clog2(NCELL + 1);

    logic [LOG_W-1:0] r_image_log2, r_min_log2;
    logic [LOG_W-1:0] size_eff, span, levels;
    t_ctl             ctl;
    logic             en, can_load, load;

    logic             s_go  [NCELL+1];
    t_pix             s_pix [NCELL+1];
    logic [CNT_W-1:0] s_cnt [NCELL+1];
    t_res             s_res [NCELL+1][NCELL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_log2 <= RST_IMAGE_SIZE;
            r_min_log2   <= RST_MIN_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_SIZE: r_image_log2 <= i_cfg_data;
                CFG_MIN_SIZE:   r_min_log2   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign size_eff = (r_image_log2 > 4'(TOP)) ? 4'(TOP) : r_image_log2;
    assign span     = (size_eff > r_min_log2) ? size_eff - r_min_log2 : '0;
    assign levels   = (span > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : span;

    assign load    = (s_cnt[NCELL] != '0) && can_load;
    assign en      = (s_cnt[NCELL] == '0) || can_load;
    assign o_stall = !en;

    assign ctl = '{en: en, clear: i_cfg_we, size_log2: size_eff, levels: levels};

    assign s_go[0]  = i_valid;
    assign s_pix[0] = '{blue: i_blue_in, green: i_green_in, red: i_red_in};
    assign s_cnt[0] = '0;
    assign s_res[0] = '{default: '0};

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rmcb_cell #(
            .MAX_SIZE  (MAX_SIZE),
            .NUM_CELLS (NCELL),
            .LEVEL     (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_go    (s_go[k]),
            .i_pix   (s_pix[k]),
            .i_cnt   (s_cnt[k]),
            .i_res   (s_res[k]),
            .o_go    (s_go[k+1]),
            .o_pix   (s_pix[k+1]),
            .o_cnt   (s_cnt[k+1]),
            .o_res   (s_res[k+1])
        );
    end

    rmcb_serial #(
        .NUM_CELLS (NCELL)
    ) u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_cnt       (s_cnt[NCELL]),
        .i_res       (s_res[NCELL]),
        .o_can_load  (can_load),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_level     (o_level),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_level_end (o_level_end),
        .o_run_last  (o_run_last)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> s_cnt[NCELL] != '0 && o_valid)
        else $error("Chain stalled with no results waiting for transfer.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable({o_level, o_red_out, o_green_out,
                                                   o_blue_out, o_level_end, o_run_last}))
        else $error("Stalled result changed before its transfer.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> en)
        else $error("Results loaded while the chain was held.");

endmodule

FILE: hw/rtl/rmcb_cell.sv
module rmcb_cell
    import rmcb_pkg::*;
#(
    parameter int MAX_SIZE  = 4096,
    parameter int NUM_CELLS = 6,
    parameter int LEVEL     = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_ctl                             i_ctl,
    input  logic                             i_go,
    input  t_pix                             i_pix,
    input  logic [$clog2(NUM_CELLS+1)-1:0]   i_cnt,
    input  t_res                             i_res [NUM_CELLS],
    output logic                             o_go,
    output t_pix                             o_pix,
    output logic [$clog2(NUM_CELLS+1)-1:0]   o_cnt,
    output t_res                             o_res [NUM_CELLS]
);

    localparam int TOP   = $clog2(MAX_SIZE + 1) - 1;
    localparam int CW    = TOP - LEVEL;
    localparam int AW    = (CW > 1) ? CW - 1 : 1;
    localparam int DEPTH = 1 << AW;
    localparam int CNT_W = $clog2(NUM_CELLS + 1);
    localparam logic [CW-1:0] ONES = {CW{1'b1}};

    logic [CW-1:0]    r_col, r_row, n_col, n_row;
    t_pix             r_held;
    t_sum             mem [DEPTH];
    t_sum             r_rd;
    logic             r_go;
    t_pix             r_pix;
    logic [CNT_W-1:0] r_cnt;
    t_res             r_res [NUM_CELLS];
    t_res             n_res [NUM_CELLS];

    logic             active, step, we, emit, col_last, row_last;
    logic [LOG_W-1:0] lw;
    logic [CW-1:0]    mask;
    logic [AW-1:0]    waddr, raddr;
    t_sum             pair;
    t_pix             avg;
    logic [9:0]       tot_r, tot_g, tot_b;

    assign active   = 4'(LEVEL) < i_ctl.levels;
    assign lw       = i_ctl.size_log2 - 4'(LEVEL);
    assign mask     = ~(ONES << lw);
    assign col_last = r_col == mask;
    assign row_last = r_row == mask;
    assign step     = i_ctl.en && i_go && active;
    assign we       = step && r_col[0] && !r_row[0];
    assign emit     = step && r_col[0] && r_row[0];

    assign pair.red   = {1'b0, r_held.red}   + {1'b0, i_pix.red};
    assign pair.green = {1'b0, r_held.green} + {1'b0, i_pix.green};
    assign pair.blue  = {1'b0, r_held.blue}  + {1'b0, i_pix.blue};

    assign tot_r = {1'b0, r_rd.red}   + {1'b0, pair.red}   + ROUND_HALF;
    assign tot_g = {1'b0, r_rd.green} + {1'b0, pair.green} + ROUND_HALF;
    assign tot_b = {1'b0, r_rd.blue}  + {1'b0, pair.blue}  + ROUND_HALF;
    assign avg.red   = tot_r[9:2];
    assign avg.green = tot_g[9:2];
    assign avg.blue  = tot_b[9:2];

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_ctl.clear) begin
            n_col = '0;
            n_row = '0;
        end else if (step) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    assign waddr = AW'(r_col >> 1);
    assign raddr = AW'(n_col >> 1);

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we && waddr == raddr) begin
            r_rd <= pair;
        end else begin
            r_rd <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
            r_go   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (step && !r_col[0]) begin
                r_held <= i_pix;
            end
            if (i_ctl.en) begin
                r_go  <= emit;
                r_cnt <= emit ? CNT_W'(LEVEL + 1) : i_cnt;
            end
        end
    end

    always_comb begin
        n_res = i_res;
        if (emit) begin
            n_res[LEVEL] = '{pix: avg, level_end: col_last && row_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_pix <= emit ? avg : i_pix;
            r_res <= n_res;
        end
    end

    assign o_go  = r_go;
    assign o_pix = r_pix;
    assign o_cnt = r_cnt;
    assign o_res = r_res;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |-> r_cnt == CNT_W'(LEVEL + 1))
        else $error("Cell passes a pixel on without counting its own result.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> r_col == '0 && r_row == '0)
        else $error("Cell position not cleared after a configuration write.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.en |=> $stable(r_go) && $stable(r_cnt))
        else $error("Cell moved on while the chain was held.");

endmodule

FILE: hw/rtl/rmcb_serial.sv
module rmcb_serial
    import rmcb_pkg::*;
#(
    parameter int NUM_CELLS = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  logic [$clog2(NUM_CELLS+1)-1:0]   i_cnt,
    input  t_res                             i_res [NUM_CELLS],
    output logic                             o_can_load,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [LEVEL_W-1:0]               o_level,
    output logic [7:0]                       o_red_out,
    output logic [7:0]                       o_green_out,
    output logic [7:0]                       o_blue_out,
    output logic                             o_level_end,
    output logic                             o_run_last
);

    localparam int CNT_W = $clog2(NUM_CELLS + 1);
    localparam int PW    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    logic             r_valid;
    logic [CNT_W-1:0] r_left;
    logic [PW-1:0]    r_pos;
    t_res             r_res [NUM_CELLS];
    t_res             head;
    logic             xfer, is_last;

    assign xfer       = r_valid && !i_stall;
    assign is_last    = r_left == CNT_W'(1);
    assign o_can_load = !r_valid || (xfer && is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
            r_pos   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_left  <= i_cnt;
            r_pos   <= '0;
        end else if (xfer) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end
            r_left <= r_left - 1'b1;
            r_pos  <= r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign head        = r_res[r_pos];
    assign o_valid     = r_valid;
    assign o_level     = 3'(r_pos) + 3'd1;
    assign o_red_out   = head.pix.red;
    assign o_green_out = head.pix.green;
    assign o_blue_out  = head.pix.blue;
    assign o_level_end = head.level_end;
    assign o_run_last  = is_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_left != '0)
        else $error("Output register valid with no results left.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_valid || (xfer && is_last))
        else $error("Results loaded over a run not yet transferred.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && !is_last |=> r_valid)
        else $error("Run ended before its last result was transferred.");

endmodule
